// ----- hdl/day_offset_to_calendar_date_unit_assert.svh -----
// Assertion macros for the day offset to calendar date unit
`ifndef DAY_OFFSET_TO_CALENDAR_DATE_UNIT_ASSERT_SVH
`define DAY_OFFSET_TO_CALENDAR_DATE_UNIT_ASSERT_SVH

// Same-cycle implication, clocked on clk, off during reset
`define DOCD_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, clocked on clk, off during reset
`define DOCD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- hdl/docd_pkg.sv -----
// Shared constants, types and calendar functions for the date unit
package docd_pkg;

  localparam int OFFSET_BITS_DEF = 16;
  localparam int YEAR_W          = 14;
  localparam int MONTH_W         = 4;
  localparam int DAY_W           = 5;
  localparam int CFG_IDX_W       = 2;
  localparam int CFG_DATA_W      = 14;
  localparam int Y400_W          = 9;
  // 146097 fits in 18 bits
  localparam int CYCLE_W         = 18;

  localparam logic [CYCLE_W-1:0] DAYS_PER_CYCLE  = 18'd146097;
  localparam logic [Y400_W-1:0]  YEARS_PER_CYCLE = 9'd400;
  localparam logic [Y400_W-1:0]  YEAR_MOD_LAST   = 9'd399;

  localparam logic [MONTH_W-1:0] MONTH_JAN = 4'd1;
  localparam logic [MONTH_W-1:0] MONTH_FEB = 4'd2;
  localparam logic [MONTH_W-1:0] MONTH_DEC = 4'd12;

  localparam logic [DAY_W-1:0] DAY_FIRST = 5'd1;
  localparam logic [DAY_W-1:0] DAY_LEAP_FEB = 5'd29;

  // Register indexes on the config port
  localparam logic [CFG_IDX_W-1:0] REG_EPOCH_YEAR  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_EPOCH_MONTH = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_EPOCH_DAY   = 2'd2;

  localparam logic [YEAR_W-1:0]  EPOCH_YEAR_RST  = 14'd2025;
  localparam logic [MONTH_W-1:0] EPOCH_MONTH_RST = 4'd1;
  localparam logic [DAY_W-1:0]   EPOCH_DAY_RST   = 5'd1;

  // Leap rule on year mod 400
  function automatic logic is_leap(input logic [Y400_W-1:0] ymod);
    return (ymod[1:0] == 2'b00) && (ymod != 9'd100) && (ymod != 9'd200) &&
           (ymod != 9'd300);
  endfunction

  // Month length table, February widened in leap years
  function automatic logic [DAY_W-1:0] days_in(input logic [MONTH_W-1:0] m,
                                               input logic leap);
    logic [DAY_W-1:0] len;
    case (m)
      4'd2:    len = leap ? DAY_LEAP_FEB : 5'd28;
      4'd4:    len = 5'd30;
      4'd6:    len = 5'd30;
      4'd9:    len = 5'd30;
      4'd11:   len = 5'd30;
      default: len = 5'd31;
    endcase
    return len;
  endfunction

endpackage

// ----- hdl/day_offset_to_calendar_date_unit.sv -----
// Top level: day offset to Gregorian date, one shared subtractor under a sequencer
// Steps per item: reduce the base year mod 400, clamp the base day, skip whole 400-year cycles,
// walk month by month, hand off to the output register; a 16-bit offset walks at most about
// 2160 months. One item at a time: in_ready is high only while idle; a finished result waits
// in an output register while the next item runs. Synchronous reset idles the sequencer,
// clears out_valid, base date 2025-01-01.
module day_offset_to_calendar_date_unit #(
  parameter int OFFSET_BITS = docd_pkg::OFFSET_BITS_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic [OFFSET_BITS-1:0]           in_day_offset,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [docd_pkg::YEAR_W-1:0]      out_year,
  output logic [docd_pkg::MONTH_W-1:0]     out_month,
  output logic [docd_pkg::DAY_W-1:0]       out_day,
  input  logic                             cfg_we,
  input  logic [docd_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [docd_pkg::CFG_DATA_W-1:0]  cfg_wdata
);

  import docd_pkg::*;

  `include "day_offset_to_calendar_date_unit_assert.svh"

  // Unit width: wide enough for the offset and for the 400-year day count
  localparam int UW = (OFFSET_BITS > CYCLE_W) ? OFFSET_BITS : CYCLE_W;

  // Sequencer states
  //   IDLE  : wait for a transfer, load base date
  //   MOD   : reduce base year mod 400 (repeated subtract)
  //   CLAMP : clip base day to its month length
  //   CYC   : skip whole 400-year cycles
  //   WALK  : one month per cycle
  //   FIN   : hand result to the output register
  typedef enum logic [5:0] {
    ST_IDLE  = 6'b000001,
    ST_MOD   = 6'b000010,
    ST_CLAMP = 6'b000100,
    ST_CYC   = 6'b001000,
    ST_WALK  = 6'b010000,
    ST_FIN   = 6'b100000
  } state_t;

  state_t state_r, state_nxt;

  // Config registers
  logic [YEAR_W-1:0]  epoch_year_r,  epoch_year_nxt;
  logic [MONTH_W-1:0] epoch_month_r, epoch_month_nxt;
  logic [DAY_W-1:0]   epoch_day_r,   epoch_day_nxt;

  // Working registers
  logic [OFFSET_BITS-1:0] rem_r,   rem_nxt;
  logic [YEAR_W-1:0]      year_r,  year_nxt;    // wraps at 14 bits like the output
  logic [YEAR_W-1:0]      y400_r,  y400_nxt;    // year mod 400 once reduced
  logic [MONTH_W-1:0]     month_r, month_nxt;
  logic [DAY_W-1:0]       day_r,   day_nxt;

  // Output register
  logic               out_valid_r, out_valid_nxt;
  logic [YEAR_W-1:0]  out_year_r,  out_year_nxt;
  logic [MONTH_W-1:0] out_month_r, out_month_nxt;
  logic [DAY_W-1:0]   out_day_r,   out_day_nxt;

  // Shared unit
  logic [UW-1:0] op_a, op_b, sub_diff;
  logic          sub_borrow;

  logic             leap;
  logic [DAY_W-1:0] dim;
  logic [DAY_W:0]   left;

  docd_sub #(
    .W (UW)
  ) u_sub (
    .a      (op_a),
    .b      (op_b),
    .diff   (sub_diff),
    .borrow (sub_borrow)
  );

  // Month length from the current month and year mod 400
  assign leap = is_leap(y400_r[Y400_W-1:0]);
  assign dim  = days_in(month_r, leap);
  // Days left in the month including today; day_r never exceeds dim here
  assign left = {1'b0, dim} - {1'b0, day_r} + (DAY_W+1)'(1);

  // Operand select for the shared subtractor
  always_comb begin
    op_a = '0;
    op_b = '0;
    unique case (state_r)
      ST_MOD: begin
        op_a = UW'(y400_r);
        op_b = UW'(YEARS_PER_CYCLE);
      end
      ST_CYC: begin
        op_a = UW'(rem_r);
        op_b = UW'(DAYS_PER_CYCLE);
      end
      ST_WALK: begin
        op_a = UW'(rem_r);
        op_b = UW'(left);
      end
      default: begin
        op_a = '0;
        op_b = '0;
      end
    endcase
  end

  always_comb begin
    state_nxt       = state_r;
    epoch_year_nxt  = epoch_year_r;
    epoch_month_nxt = epoch_month_r;
    epoch_day_nxt   = epoch_day_r;
    rem_nxt         = rem_r;
    year_nxt        = year_r;
    y400_nxt        = y400_r;
    month_nxt       = month_r;
    day_nxt         = day_r;
    out_valid_nxt   = out_valid_r && !out_ready;
    out_year_nxt    = out_year_r;
    out_month_nxt   = out_month_r;
    out_day_nxt     = out_day_r;

    // Writes to an unlisted index fall through untouched
    if (cfg_we) begin
      if (cfg_index == REG_EPOCH_YEAR) begin
        epoch_year_nxt = cfg_wdata[YEAR_W-1:0];
      end else if (cfg_index == REG_EPOCH_MONTH) begin
        epoch_month_nxt = cfg_wdata[MONTH_W-1:0];
      end else if (cfg_index == REG_EPOCH_DAY) begin
        epoch_day_nxt = cfg_wdata[DAY_W-1:0];
      end
    end

    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          rem_nxt  = in_day_offset;
          year_nxt = epoch_year_r;
          y400_nxt = epoch_year_r;
          // Out-of-range base month clipped into January..December
          if (epoch_month_r == '0) begin
            month_nxt = MONTH_JAN;
          end else if (epoch_month_r > MONTH_DEC) begin
            month_nxt = MONTH_DEC;
          end else begin
            month_nxt = epoch_month_r;
          end
          day_nxt   = (epoch_day_r == '0) ? DAY_FIRST : epoch_day_r;
          state_nxt = ST_MOD;
        end
      end
      ST_MOD: begin
        if (!sub_borrow) begin
          y400_nxt = sub_diff[YEAR_W-1:0];
        end else begin
          state_nxt = ST_CLAMP;
        end
      end
      ST_CLAMP: begin
        if (day_r > dim) begin
          day_nxt = dim;
        end
        state_nxt = ST_CYC;
      end
      ST_CYC: begin
        // Whole 400-year cycles leave year mod 400 unchanged
        if (!sub_borrow) begin
          rem_nxt  = sub_diff[OFFSET_BITS-1:0];
          year_nxt = year_r + YEAR_W'(YEARS_PER_CYCLE);
        end else begin
          state_nxt = ST_WALK;
        end
      end
      ST_WALK: begin
        if (rem_r == '0) begin
          state_nxt = ST_FIN;
        end else if (sub_borrow) begin
          // Remainder fits inside this month; it is below left, so five bits do
          day_nxt   = day_r + rem_r[DAY_W-1:0];
          rem_nxt   = '0;
          state_nxt = ST_FIN;
        end else begin
          rem_nxt = sub_diff[OFFSET_BITS-1:0];
          day_nxt = DAY_FIRST;
          if (month_r == MONTH_DEC) begin
            month_nxt = MONTH_JAN;
            year_nxt  = year_r + YEAR_W'(1);
            y400_nxt  = (y400_r[Y400_W-1:0] == YEAR_MOD_LAST) ? '0 :
                        y400_r + YEAR_W'(1);
          end else begin
            month_nxt = month_r + MONTH_W'(1);
          end
        end
      end
      ST_FIN: begin
        // Wait for the output register to free up
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          out_year_nxt  = year_r;
          out_month_nxt = month_r;
          out_day_nxt   = day_r;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ST_IDLE;
      out_valid_r   <= 1'b0;
      epoch_year_r  <= EPOCH_YEAR_RST;
      epoch_month_r <= EPOCH_MONTH_RST;
      epoch_day_r   <= EPOCH_DAY_RST;
    end else begin
      state_r       <= state_nxt;
      out_valid_r   <= out_valid_nxt;
      epoch_year_r  <= epoch_year_nxt;
      epoch_month_r <= epoch_month_nxt;
      epoch_day_r   <= epoch_day_nxt;
    end
  end

  // Datapath, no reset needed
  always_ff @(posedge clk) begin
    rem_r       <= rem_nxt;
    year_r      <= year_nxt;
    y400_r      <= y400_nxt;
    month_r     <= month_nxt;
    day_r       <= day_nxt;
    out_year_r  <= out_year_nxt;
    out_month_r <= out_month_nxt;
    out_day_r   <= out_day_nxt;
  end

  assign in_ready  = (state_r == ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_year  = out_year_r;
  assign out_month = out_month_r;
  assign out_day   = out_day_r;

  // A transfer always starts the year reduction
  `DOCD_ASSERT_NEXT(a_accept_starts, in_valid && in_ready, state_r == ST_MOD, "accept did not start")
  // Year mod 400 is fully reduced before the walk uses it
  `DOCD_ASSERT_IMPL(a_y400_reduced, state_r == ST_WALK, y400_r < YEAR_W'(YEARS_PER_CYCLE), "y400 out of range")
  // The walk never holds a day past the end of its month
  `DOCD_ASSERT_IMPL(a_day_in_month, state_r == ST_WALK, day_r <= dim && day_r != '0, "day outside month")
  // Delivered month is always a real month
  `DOCD_ASSERT_IMPL(a_out_month, out_valid, out_month != '0 && out_month <= MONTH_DEC, "bad out month")

endmodule

// ----- hdl/docd_sub.sv -----
// Shared subtract/compare unit used by the year reduction, cycle skip and month walk steps of the date sequencer
module docd_sub #(
  parameter int W = 18
) (
  input  logic [W-1:0] a,
  input  logic [W-1:0] b,
  output logic [W-1:0] diff,
  output logic         borrow
);

  assign {borrow, diff} = {1'b0, a} - {1'b0, b};

endmodule

// ----- tb/sv/day_offset_to_calendar_date_checker.sv -----
// Checker for the date unit: tracks the base date, predicts each date and compares results
module day_offset_to_calendar_date_checker #(
  parameter int OFF_W = docd_pkg::OFFSET_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  input  logic                            in_ready,
  input  logic [OFF_W-1:0]                in_day_offset,
  input  logic                            out_valid,
  input  logic                            out_ready,
  input  logic [docd_pkg::YEAR_W-1:0]     out_year,
  input  logic [docd_pkg::MONTH_W-1:0]    out_month,
  input  logic [docd_pkg::DAY_W-1:0]      out_day,
  input  logic                            cfg_we,
  input  logic [docd_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [docd_pkg::CFG_DATA_W-1:0] cfg_wdata,
  output int                              date_errors,
  output int                              dates_due
);
  timeunit 1ns;
  timeprecision 1ps;

  import docd_pkg::*;

  typedef struct packed {
    logic [YEAR_W-1:0]  year;
    logic [MONTH_W-1:0] month;
    logic [DAY_W-1:0]   day;
  } cal_date_t;

  logic [YEAR_W-1:0]  epoch_year  = EPOCH_YEAR_RST;
  logic [MONTH_W-1:0] epoch_month = EPOCH_MONTH_RST;
  logic [DAY_W-1:0]   epoch_day   = EPOCH_DAY_RST;

  cal_date_t due_q[$];
  int        err_count = 0;

  function automatic bit leap(int unsigned yr);
    return ((yr % 4) == 0 && (yr % 100) != 0) || ((yr % 400) == 0);
  endfunction

  function automatic int unsigned month_len(int unsigned yr, int unsigned mo);
    case (mo)
      2:           return leap(yr) ? 29 : 28;
      4, 6, 9, 11: return 30;
      default:     return 31;
    endcase
  endfunction

  // Skip whole 400-year cycles, then walk month by month from the clamped base date
  function automatic cal_date_t date_after(logic [OFF_W-1:0] offset);
    int unsigned rem;
    int unsigned yr;
    int unsigned mo;
    int unsigned dy;
    int unsigned left;
    cal_date_t   res;
    rem = offset;
    yr  = epoch_year;
    mo  = epoch_month;
    dy  = epoch_day;
    if (mo < 1) mo = 1;
    if (mo > 12) mo = 12;
    if (dy < 1) dy = 1;
    if (dy > month_len(yr, mo)) dy = month_len(yr, mo);
    yr  += (rem / DAYS_PER_CYCLE) * YEARS_PER_CYCLE;
    rem  = rem % DAYS_PER_CYCLE;
    while (rem > 0) begin
      left = month_len(yr, mo) - dy + 1;
      if (rem < left) begin
        dy  += rem;
        rem  = 0;
      end else begin
        rem -= left;
        dy   = 1;
        mo++;
        if (mo > 12) begin
          mo = 1;
          yr++;
        end
      end
    end
    res.year  = YEAR_W'(yr);
    res.month = MONTH_W'(mo);
    res.day   = DAY_W'(dy);
    return res;
  endfunction

  always @(posedge clk) begin
    cal_date_t want;
    if (!rst_n) begin
      epoch_year  = EPOCH_YEAR_RST;
      epoch_month = EPOCH_MONTH_RST;
      epoch_day   = EPOCH_DAY_RST;
      due_q.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_EPOCH_YEAR:  epoch_year  = cfg_wdata[YEAR_W-1:0];
          REG_EPOCH_MONTH: epoch_month = cfg_wdata[MONTH_W-1:0];
          REG_EPOCH_DAY:   epoch_day   = cfg_wdata[DAY_W-1:0];
          default: ;
        endcase
      end
      if (in_valid && in_ready)
        due_q = {due_q, date_after(in_day_offset)};
      if (out_valid && out_ready) begin
        if (due_q.size() == 0) begin
          $error("result transfer %0d-%0d-%0d with no date due", out_year, out_month, out_day);
          err_count++;
        end else begin
          want = due_q.pop_front();
          if (out_year !== want.year) begin
            $error("year: expected %0d, got %0d", want.year, out_year);
            err_count++;
          end
          if (out_month !== want.month) begin
            $error("month: expected %0d, got %0d", want.month, out_month);
            err_count++;
          end
          if (out_day !== want.day) begin
            $error("day: expected %0d, got %0d", want.day, out_day);
            err_count++;
          end
        end
      end
    end
    dates_due   <= due_q.size();
    date_errors <= err_count;
  end

endmodule

// ----- tb/sv/day_offset_to_calendar_date_unit_tb.sv -----
// Testbench top for the date unit: stimulus, base date settings and the verdict
module day_offset_to_calendar_date_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import docd_pkg::*;

  localparam int OFF_W = OFFSET_BITS_DEF;
  // Index with no register behind it; writes there must be ignored
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;
  localparam int RAND_PHASES     = 8;
  localparam int ITEMS_PER_PHASE = 29;

  // Receiver behaviour, changed every so often
  typedef enum logic [1:0] {SINK_OPEN, SINK_CHOPPY, SINK_CLOGGED} sink_mode_t;

  logic                  clk           = 1'b0;
  logic                  rst_n         = 1'b0;
  logic                  in_valid      = 1'b0;
  logic                  in_ready;
  logic [OFF_W-1:0]      in_day_offset = '0;
  logic                  out_valid;
  logic                  out_ready     = 1'b0;
  logic [YEAR_W-1:0]     out_year;
  logic [MONTH_W-1:0]    out_month;
  logic [DAY_W-1:0]      out_day;
  logic                  cfg_we        = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index     = REG_EPOCH_YEAR;
  logic [CFG_DATA_W-1:0] cfg_wdata     = '0;

  int         date_errors;
  int         dates_due;
  int         burst_left = 0;
  int         sink_left  = 0;
  sink_mode_t sink_mode  = SINK_OPEN;

  day_offset_to_calendar_date_unit #(
    .OFFSET_BITS(OFF_W)
  ) i_dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_day_offset(in_day_offset),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_year     (out_year),
    .out_month    (out_month),
    .out_day      (out_day),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_wdata    (cfg_wdata)
  );

  day_offset_to_calendar_date_checker #(
    .OFF_W(OFF_W)
  ) i_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_day_offset(in_day_offset),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_year     (out_year),
    .out_month    (out_month),
    .out_day      (out_day),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_wdata    (cfg_wdata),
    .date_errors  (date_errors),
    .dates_due    (dates_due)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  // Hard stop well past the slowest legal run
  initial begin
    #12ms;
    $display("DONE: errors detected");
    $finish;
  end

  // Receiver: open, choppy or mostly clogged, each for a random stretch
  always @(posedge clk) begin
    if (sink_left == 0) begin
      sink_mode = sink_mode_t'($urandom_range(0, 2));
      sink_left = $urandom_range(4, 200);
    end else begin
      sink_left--;
    end
    case (sink_mode)
      SINK_OPEN:    out_ready <= 1'b1;
      SINK_CHOPPY:  out_ready <= 1'($urandom_range(0, 1));
      default:      out_ready <= ($urandom_range(0, 3) == 0);
    endcase
  end

  // One register write; the spare cycle after it keeps cfg_we from being
  // dropped and raised in the same step when writes follow one another
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int unsigned data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= CFG_DATA_W'(data);
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_base(input int unsigned yr, input int unsigned mo, input int unsigned dy);
    write_reg(REG_EPOCH_YEAR, yr);
    write_reg(REG_EPOCH_MONTH, mo);
    write_reg(REG_EPOCH_DAY, dy);
  endtask

  // Sender in bursts: valid held across a burst, dropped for a gap between bursts.
  // Long gaps land on varying points of the month walk.
  task automatic send_offset(input logic [OFF_W-1:0] offset);
    if (burst_left == 0) begin
      if ($urandom_range(0, 3) == 0)
        repeat ($urandom_range(20, 300)) @(posedge clk);
      else
        repeat ($urandom_range(1, 6)) @(posedge clk);
      burst_left = $urandom_range(1, 12);
    end
    in_valid      <= 1'b1;
    in_day_offset <= offset;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    // transfer taken at this edge
    burst_left--;
    if (burst_left == 0) in_valid <= 1'b0;
  endtask

  // Hold the sender until every date due has come back; the block is idle then
  task automatic drain_dates();
    // a finished burst has already dropped valid in this step
    if (burst_left != 0) in_valid <= 1'b0;
    burst_left = 0;
    @(posedge clk);
    while (dates_due != 0) @(posedge clk);
  endtask

  // Mostly short walks, a few across the whole offset range
  function automatic logic [OFF_W-1:0] pick_offset();
    case ($urandom_range(0, 15))
      0, 1:    return OFF_W'($urandom_range(0, (1 << OFF_W) - 1));
      2, 3:    return OFF_W'($urandom_range(0, 40));
      default: return OFF_W'($urandom_range(0, 1500));
    endcase
  endfunction

  initial begin
    int unsigned yr;
    int unsigned mo;
    int unsigned dy;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset base date 2025-01-01: month and year edges, widest offset
    send_offset(0);
    send_offset(1);
    send_offset(31);
    send_offset(59);
    send_offset(364);
    send_offset(365);
    send_offset({OFF_W{1'b1}});
    drain_dates();

    // Century year that is not leap: Feb 28 steps to Mar 1
    set_base(1900, 2, 28);
    send_offset(1);
    send_offset(0);
    drain_dates();

    // Divisible by 400, so leap: Feb 29 exists
    set_base(2000, 2, 28);
    send_offset(1);
    send_offset(2);
    drain_dates();

    // Year zero counts as leap; month 0 and day 0 clamp to 1
    set_base(0, 0, 0);
    send_offset(0);
    send_offset(59);
    drain_dates();

    // Top year with month above 12: clamps to December, year wraps past 16383
    set_base(16383, 15, 31);
    send_offset(0);
    send_offset(1);
    send_offset({OFF_W{1'b1}});
    drain_dates();

    // Day beyond a short February clamps to 28; spare index write must not land
    set_base(2023, 2, 31);
    write_reg(REG_UNUSED, 16383);
    send_offset(0);
    send_offset(1);
    drain_dates();

    // Day 31 in a 30-day month clamps to 30
    set_base(2024, 4, 31);
    send_offset(0);
    send_offset(1);
    drain_dates();

    // Lowest base date, widest offset
    set_base(1, 1, 1);
    send_offset({OFF_W{1'b1}});
    drain_dates();

    // Random base dates, mostly valid, with some out-of-range and full-width values
    for (int ph = 0; ph < RAND_PHASES; ph++) begin
      if ($urandom_range(0, 7) == 0)
        yr = $urandom_range(0, (1 << YEAR_W) - 1);
      else
        yr = $urandom_range(1, 9000);
      if ($urandom_range(0, 7) == 0)
        mo = $urandom_range(0, (1 << MONTH_W) - 1);
      else
        mo = $urandom_range(1, 12);
      if ($urandom_range(0, 7) == 0)
        dy = $urandom_range(0, (1 << DAY_W) - 1);
      else
        dy = $urandom_range(1, 31);
      set_base(yr, mo, dy);
      if ($urandom_range(0, 3) == 0)
        write_reg(REG_UNUSED, $urandom_range(0, (1 << CFG_DATA_W) - 1));
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        send_offset(pick_offset());
        // now and then let the pipeline run dry mid-phase
        if (n == ITEMS_PER_PHASE / 2 && $urandom_range(0, 2) == 0)
          drain_dates();
      end
      drain_dates();
    end

    // Settle: nothing due, then a margin past the unit's worst latency
    drain_dates();
    repeat (2500) @(posedge clk);
    if (date_errors == 0 && dates_due == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end

endmodule

// ----- day_offset_to_calendar_date_unit.f -----
+incdir+hdl
hdl/docd_pkg.sv
hdl/docd_sub.sv
hdl/day_offset_to_calendar_date_unit.sv
tb/sv/day_offset_to_calendar_date_checker.sv
tb/sv/day_offset_to_calendar_date_unit_tb.sv
